@@ rtl/sha_pkg.sv @@
package sha_pkg;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic [15:0][31:0] words;
    logic              fin;
  } blk_t;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  function automatic word_t init_hash(input logic [2:0] i);
    word_t r;
    case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic word_t round_k(input logic [5:0] i);
    word_t r;
    case (i)
      6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;  6'd2: r = 32'hb5c0fbcf;
      6'd3: r = 32'he9b5dba5;  6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
      6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;  6'd8: r = 32'hd807aa98;
      6'd9: r = 32'h12835b01;  6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

  function automatic word_t big_sig0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sig1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t sml_sig0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t sml_sig1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'h000, x[31:10]};
  endfunction

endpackage

@@ rtl/sha_fifo.sv @@
module sha_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  sha_pkg::blk_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output sha_pkg::blk_t pop_data
);

  sha_pkg::blk_t ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = ent_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop) rd_ptr_r <= ~rd_ptr_r;
      if (do_push && !do_pop) cnt_r <= cnt_r + 2'd1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wr_ptr_r] <= push_data;
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("fifo count out of range");
  a_cnt_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("fifo pointers disagree with count");
`endif

endmodule

@@ rtl/sha_front.sv @@
module sha_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    in_msg_byte,
  input  logic          in_byte_valid,
  input  logic          in_end_of_message,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          blk_valid,
  input  logic          blk_ready,
  output sha_pkg::blk_t blk
);

  typedef enum logic [2:0] {S_IN, S_MARK, S_ZERO, S_LEN, S_PUSH} state_t;

  state_t            state_r, state_nxt, ret_r, ret_nxt, tgt;
  logic [5:0]        fill_r, fill_nxt;
  logic [63:0]       cnt_r, cnt_nxt, len_r, len_nxt;
  logic [2:0]        lenb_r, lenb_nxt;
  logic              fin_r, fin_nxt;
  logic [15:0][31:0] words_r, words_nxt;
  logic              put_en;
  logic [7:0]        put_b;
  logic [1:0]        bsel;

  assign in_ready  = (state_r == S_IN);
  assign blk_valid = (state_r == S_PUSH);
  assign blk.words = words_r;
  assign blk.fin   = fin_r;
  assign bsel      = 2'd3 - fill_r[1:0];

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    lenb_nxt  = lenb_r;
    fin_nxt   = fin_r;
    put_en    = 1'b0;
    put_b     = 8'h00;
    tgt       = state_r;
    case (state_r)
      S_IN: begin
        if (in_valid) begin
          tgt = in_end_of_message ? S_MARK : S_IN;
          if (in_byte_valid) begin
            put_en  = 1'b1;
            put_b   = in_msg_byte;
            cnt_nxt = cnt_r + 64'd8;
          end
          if (in_end_of_message) begin
            len_nxt  = in_byte_valid ? cnt_r + 64'd8 : cnt_r;
            cnt_nxt  = '0;
            lenb_nxt = 3'd0;
          end
          state_nxt = tgt;
        end
      end
      S_MARK: begin
        put_en    = 1'b1;
        put_b     = sha_pkg::PAD_MARK;
        tgt       = (fill_r + 6'd1 == sha_pkg::LEN_POS) ? S_LEN : S_ZERO;
        state_nxt = tgt;
      end
      S_ZERO: begin
        put_en    = 1'b1;
        tgt       = (fill_r + 6'd1 == sha_pkg::LEN_POS) ? S_LEN : S_ZERO;
        state_nxt = tgt;
      end
      S_LEN: begin
        put_en   = 1'b1;
        put_b    = len_r[{3'd7 - lenb_r, 3'b000} +: 8];
        lenb_nxt = lenb_r + 3'd1;
        if (lenb_r == 3'd7) begin
          tgt     = S_IN;
          fin_nxt = 1'b1;
        end else begin
          tgt = S_LEN;
        end
        state_nxt = tgt;
      end
      S_PUSH: begin
        if (blk_ready) begin
          state_nxt = ret_r;
          fin_nxt   = 1'b0;
        end
      end
      default: state_nxt = S_IN;
    endcase
    // a byte landing at offset 63 closes the block: hand it off first
    if (put_en && fill_r == 6'd63) begin
      ret_nxt   = tgt;
      state_nxt = S_PUSH;
    end
  end

  always_comb begin
    words_nxt = words_r;
    fill_nxt  = fill_r;
    if (put_en) begin
      if (fill_r[1:0] == 2'd0) words_nxt[fill_r[5:2]] = {put_b, 24'h000000};
      else words_nxt[fill_r[5:2]][{bsel, 3'b000} +: 8] = put_b;
      fill_nxt = fill_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IN;
      ret_r   <= S_IN;
      fill_r  <= '0;
      cnt_r   <= '0;
      lenb_r  <= '0;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      fill_r  <= fill_nxt;
      cnt_r   <= cnt_nxt;
      lenb_r  <= lenb_nxt;
      fin_r   <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    words_r <= words_nxt;
    len_r   <= len_nxt;
  end

`ifndef SYNTHESIS
  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH) |-> (fill_r == 6'd0))
    else $error("block handed off before it is full");
`endif

endmodule

@@ rtl/sha_core.sv @@
module sha_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          blk_valid,
  output logic          blk_ready,
  input  sha_pkg::blk_t blk,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   out_digest_word,
  output logic [2:0]    out_word_index,
  output logic          out_last_word
);

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_DONE} state_t;

  state_t            state_r;
  logic [5:0]        rnd_r;
  logic              fin_r;
  logic [7:0][31:0]  chain_r, v_r, dig_r, sum;
  logic [15:0][31:0] w_r;
  logic              ov_r;
  logic [2:0]        idx_r;
  sha_pkg::word_t    t1, t2, w_new;

  assign blk_ready       = (state_r == C_IDLE);
  assign out_valid       = ov_r;
  assign out_digest_word = dig_r[idx_r];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == 3'd7);

  assign t1 = v_r[7] + sha_pkg::big_sig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + sha_pkg::round_k(rnd_r) + w_r[0];
  assign t2 = sha_pkg::big_sig0(v_r[0])
            + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  assign w_new = sha_pkg::sml_sig1(w_r[14]) + w_r[9] + sha_pkg::sml_sig0(w_r[1]) + w_r[0];

  always_comb begin
    for (int i = 0; i < 8; i++) sum[i] = chain_r[i] + v_r[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      rnd_r   <= '0;
      fin_r   <= 1'b0;
      ov_r    <= 1'b0;
      idx_r   <= '0;
      for (int i = 0; i < 8; i++) chain_r[i] <= sha_pkg::init_hash(3'(i));
    end else begin
      if (ov_r && out_ready) begin
        if (idx_r == 3'd7) ov_r <= 1'b0;
        idx_r <= idx_r + 3'd1;
      end
      case (state_r)
        C_IDLE: begin
          if (blk_valid) begin
            fin_r   <= blk.fin;
            rnd_r   <= '0;
            state_r <= C_RUN;
          end
        end
        C_RUN: begin
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) state_r <= C_DONE;
        end
        C_DONE: begin
          if (!fin_r) begin
            chain_r <= sum;
            state_r <= C_IDLE;
          end else if (!ov_r) begin
            // last block of a message: park digest, restart chain
            for (int i = 0; i < 8; i++) chain_r[i] <= sha_pkg::init_hash(3'(i));
            ov_r    <= 1'b1;
            idx_r   <= '0;
            state_r <= C_IDLE;
          end
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == C_IDLE && blk_valid) begin
      w_r <= blk.words;
      v_r <= chain_r;
    end else if (state_r == C_RUN) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_new;
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
    if (state_r == C_DONE && fin_r && !ov_r) dig_r <= sum;
  end

`ifndef SYNTHESIS
  a_idle_rnd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == C_IDLE) |-> (rnd_r == 6'd0 || rnd_r == 6'd63 + 6'd1))
    else $error("round counter not at start while idle");
  a_dig_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> $stable(dig_r) && $stable(idx_r))
    else $error("digest changed under a stalled beat");
`endif

endmodule

@@ rtl/sha256_message_hasher_top.sv @@
// SHA-256 message hasher.
// Input channel: one beat per message byte (in_msg_byte, qualified by
// in_byte_valid); in_end_of_message closes the message, a valid byte in the
// same beat counts first. A beat with neither flag set does nothing.
// Output channel: after each message end, eight beats carry the digest,
// word 0 (most significant) first, out_word_index 0..7, out_last_word on 7.
// The packer takes a byte whenever in_ready is high and drops in_ready to
// hand off each 64-byte block as it fills; the core works each block in
// steps (load, 64 rounds, chain update) and takes no new block until done.
// Padding is written a byte per cycle, apart from block hand-offs (9 to 72
// bytes for the end of a message). A two-block queue sits between packer and
// core, so bytes keep flowing while a block compresses.
// The digest sits in its own register; a stalled receiver only holds up the
// core once the next message's final block is done.
// Reset (rst_n low, synchronous) empties the queue, clears byte and bit
// counts and loads the initial hash values.
module sha256_message_hasher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_msg_byte,
  input  logic        in_byte_valid,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  sha_pkg::blk_t f_blk, q_blk;
  logic          f_valid, f_ready, q_valid, q_ready;

  sha_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_msg_byte       (in_msg_byte),
    .in_byte_valid     (in_byte_valid),
    .in_end_of_message (in_end_of_message),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .blk_valid         (f_valid),
    .blk_ready         (f_ready),
    .blk               (f_blk)
  );

  sha_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_blk),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_blk)
  );

  sha_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .blk_valid       (q_valid),
    .blk_ready       (q_ready),
    .blk             (q_blk),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

endmodule

@@ sim/tb_sha256_message_hasher_top.sv @@
module tb_sha256_message_hasher_top;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_msg_byte;
  logic        in_byte_valid;
  logic        in_end_of_message;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_beat_t;

  class digest_scoreboard;
    logic [31:0]  hash_state[8];
    logic [31:0]  blk[16];
    logic [5:0]   fill;
    logic [63:0]  msg_bits;
    digest_beat_t pending[$];
    int           errors;
    int           digests;

    function new();
      restart();
      errors = 0;
      digests = 0;
    endfunction

    function void restart();
      hash_state = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                     32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      fill = '0;
      msg_bits = '0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [31:0] w[16];
      logic [31:0] v[8];
      logic [31:0] t1, t2, a2, a15;
      w = blk;
      v = hash_state;
      for (int r = 0; r < 64; r++) begin
        if (r >= 16) begin
          a2 = w[(r - 2) & 15];
          a15 = w[(r - 15) & 15];
          w[r & 15] = (ror(a2, 17) ^ ror(a2, 19) ^ (a2 >> 10)) + w[(r - 7) & 15]
                      + (ror(a15, 7) ^ ror(a15, 18) ^ (a15 >> 3)) + w[r & 15];
        end
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
             + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::round_k(r[5:0]) + w[r & 15];
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
             + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endfunction

    function void pack_byte(logic [7:0] b);
      if (fill[1:0] == 2'd0) blk[fill[5:2]] = '0;
      blk[fill[5:2]] |= 32'(b) << ((3 - fill[1:0]) * 8);
      fill++;
      if (fill == 0) compress();
    endfunction

    function void note_input(logic [7:0] b, logic bv, logic eom);
      logic [63:0] len;
      if (bv) begin
        pack_byte(b);
        msg_bits += 64'd8;
      end
      if (!eom) return;
      len = msg_bits;
      pack_byte(sha_pkg::PAD_MARK);
      while (fill != sha_pkg::LEN_POS) pack_byte(8'h00);
      for (int i = 0; i < 8; i++) pack_byte(len[63 - 8 * i -: 8]);
      for (int i = 0; i < 8; i++)
        pending.push_back('{hash_state[i], 3'(i), i == 7});
      digests++;
      restart();
    endfunction

    function void check_result(logic [31:0] dw, logic [2:0] wi, logic lw);
      digest_beat_t e;
      if (pending.size() == 0) begin
        $error("unexpected digest beat %h idx %0d", dw, wi);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (dw !== e.digest_word) begin
        $error("digest_word exp %h got %h", e.digest_word, dw);
        errors++;
      end
      if (wi !== e.word_index) begin
        $error("word_index exp %0d got %0d", e.word_index, wi);
        errors++;
      end
      if (lw !== e.last_word) begin
        $error("last_word exp %0d got %0d", e.last_word, lw);
        errors++;
      end
    endfunction
  endclass

  digest_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int beats_sent;

  sha256_message_hasher_top DUT (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #20000000;
    $display("sha256_message_hasher_top test failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_result(out_digest_word, out_word_index, out_last_word);
      if (in_valid && in_ready)
        sb.note_input(in_msg_byte, in_byte_valid, in_end_of_message);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_beat(logic [7:0] b, logic bv, logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_msg_byte <= b;
    in_byte_valid <= bv;
    in_end_of_message <= eom;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_message(int len, int fixed_val);
    for (int i = 0; i < len; i++) begin
      // occasional idle beat inside a message
      if ($urandom_range(15) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
      send_beat(fixed_val < 0 ? 8'($urandom) : 8'(fixed_val), 1'b1, 1'b0);
    end
    // end either with its own byte or as an end-only beat
    if (len > 0 && $urandom_range(1))
      send_beat(8'($urandom), 1'b1, 1'b1);
    else
      send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    int sizes[$];
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_msg_byte = '0;
    in_byte_valid = 1'b0;
    in_end_of_message = 1'b0;
    out_ready = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    beats_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle beat, empty message, "abc", padding boundaries
    send_beat(8'hff, 1'b0, 1'b0);
    send_message(0, 0);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);
    drain();
    // 56 bytes forces an extra padding block; 63 fills a block at the end
    sizes = '{56, 63};
    foreach (sizes[i]) send_message(sizes[i], -1);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 67 : 0;
      recv_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 15 : 0;
      for (int m = 0; m < 4; m++) begin
        send_message($urandom_range(0, 3), -1);
        if (m == 1) drain();
      end
      drain();
    end

    repeat (300) @(posedge clk);
    $display("Sent %0d input beats; checked %0d digests across idle/stall mixes.",
             beats_sent, sb.digests);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("sha256_message_hasher_top test passed");
    else
      $display("sha256_message_hasher_top test failed");
    $finish;
  end
endmodule
